// File: sv/huber_vector_misfit_gradient_assert.svh
// ----------------------------------------------------------------------------
// Huber vector misfit assertion macros
// Shared property templates for the block's checks, clocked on clk_i and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HUBER_VECTOR_MISFIT_GRADIENT_ASSERT_SVH
`define HUBER_VECTOR_MISFIT_GRADIENT_ASSERT_SVH

// Same-cycle implication
`define HVMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("hvmg check failed");

// Next-cycle implication
`define HVMG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hvmg check failed");

`endif

// File: sv/hvmg_pkg.sv
// ----------------------------------------------------------------------------
// Huber vector misfit package
// Types, constants and helper functions shared by the misfit/gradient block.
// ----------------------------------------------------------------------------
`default_nettype none

package hvmg_pkg;

  localparam int FRAC_BITS = 16;
  // Width of the shifted threshold dividend, delta << FRAC_BITS
  localparam int DIV_W     = 31 + FRAC_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int SQRT_ITER = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_INV_NORM  = 2'd1;
  localparam logic [1:0] CFG_USE_WGT   = 2'd2;

  // Mul-shift operation codes, in issue order
  localparam logic [2:0] OP_TERM  = 3'd0;
  localparam logic [2:0] OP_FAC_U = 3'd1;
  localparam logic [2:0] OP_FAC_V = 3'd2;
  localparam logic [2:0] OP_WGT_U = 3'd3;
  localparam logic [2:0] OP_WGT_V = 3'd4;
  localparam logic [2:0] OP_INV_U = 3'd5;
  localparam logic [2:0] OP_INV_V = 3'd6;
  localparam logic [2:0] OP_TOTAL = 3'd7;

  typedef struct packed {
    logic signed [31:0] res_u;
    logic signed [31:0] res_v;
    logic [31:0]        weight;
    logic               last;
  } hvmg_in_t;

  typedef struct packed {
    logic signed [31:0] grad_u;
    logic signed [31:0] grad_v;
    logic [62:0]        misfit_total;
    logic               sum_valid;
  } hvmg_out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } hvmg_mul_op_t;

  // Apply sign to a magnitude and saturate to 32 bits
  function automatic logic signed [31:0] sat32(input logic [63:0] mag, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (mag >= 64'h0000_0000_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(mag[31:0]);
    end else begin
      if (|mag[63:31]) r = 32'sh7FFF_FFFF;
      else r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/hvmg_mult.sv
// ----------------------------------------------------------------------------
// Huber vector misfit shared multiplier
// One 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module hvmg_mult (
  input  wire logic                  clk_i,
  input  wire hvmg_pkg::hvmg_mul_op_t op_i,
  output logic [63:0]                prod_o
);
  import hvmg_pkg::*;

  logic [63:0] prod_q;

  // Register the product every cycle
  always_ff @(posedge clk_i) begin
    prod_q <= {32'd0, op_i.a} * {32'd0, op_i.b};
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// File: sv/huber_vector_misfit_gradient.sv
// ----------------------------------------------------------------------------
// Huber vector misfit with gradient
// Per-point Huber term and weighted gradient of a 2-D residual, with a
// saturating misfit accumulator reported on the last point.
// ----------------------------------------------------------------------------
//  channel   | signals                          | moves
//  ----------+----------------------------------+----------------------------
//  in        | in_valid_i/in_ready_o/in_data_i  | residual, weight, last
//  out       | out_valid_o/out_ready_i/out_data_o | gradient pair, total
//  cfg       | cfg_we_i/cfg_idx_i/cfg_data_i    | register writes
//
//  In the linear zone the sequencer adds SQRT_ITER (32) square-root steps, the
//  setup states S_LIN1 and S_LIN2, and DIV_W (47) divide steps. Every multiply
//  goes through the one 32x32 unit; a mul-shift steps through S_MS0, S_MS1, S_MS2.
//  Reset clears the sequencer, accumulator and registers; no clearing pass.
//  in_ready_o is high only in idle; a held result stalls the sequencer at the
//  end of the next transaction until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module huber_vector_misfit_gradient (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire hvmg_pkg::hvmg_in_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hvmg_pkg::hvmg_out_t      out_data_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_idx_i,
  input  wire logic [31:0]         cfg_data_i
);
  import hvmg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MU, S_MV, S_DS, S_CMP, S_SQRT, S_LIN1, S_LIN2, S_DIV,
    S_MS0, S_MS1, S_MS2, S_DONE
  } state_e;

  state_e      state_q;
  logic [30:0] thr_q;
  logic [31:0] inv_q;
  logic        usew_q;
  logic [63:0] acc_q;
  logic [31:0] mu_q, mv_q, w_q, mag_q;
  logic        neg_u_q, neg_v_q, last_q;
  logic [63:0] rsq_q, dsq_q, rho_q, sq_res_q, sq_bit_q, ms_lo_q, gu_q, gv_q, total_q;
  logic [DIV_W-1:0] div_q;
  logic [32:0] rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [2:0]  op_q;
  logic        out_valid_q;
  hvmg_out_t   out_q;

  hvmg_mul_op_t mul_op;
  logic [63:0]  prod;

  hvmg_mult u_mult (
    .clk_i  (clk_i),
    .op_i   (mul_op),
    .prod_o (prod)
  );

  // Square-root step
  logic [63:0] sq_rb, sq_res_nxt;
  logic        sq_ge;
  // Divide step
  logic [32:0] div_sh;
  logic        div_ge;
  // Mul-shift combine
  logic [63:0] ms_a;
  logic [31:0] ms_b;
  logic [95:0] ms_full;
  logic [63:0] ms_res;
  logic [64:0] acc_sum;
  logic [63:0] acc_nxt;
  // Result handoff to the output register
  logic        done_fire;

  always_comb begin
    sq_rb      = sq_res_q + sq_bit_q;
    sq_ge      = rsq_q >= sq_rb;
    sq_res_nxt = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

    div_sh = {rem_q[31:0], div_q[DIV_W-1]};
    div_ge = div_sh >= {1'b0, mag_q};

    unique case (op_q)
      OP_TERM:  begin ms_a = rho_q;            ms_b = w_q;          end
      OP_FAC_U: begin ms_a = {32'd0, mu_q};    ms_b = div_q[31:0];  end
      OP_FAC_V: begin ms_a = {32'd0, mv_q};    ms_b = div_q[31:0];  end
      OP_WGT_U: begin ms_a = gu_q;             ms_b = w_q;          end
      OP_WGT_V: begin ms_a = gv_q;             ms_b = w_q;          end
      OP_INV_U: begin ms_a = gu_q;             ms_b = inv_q;        end
      OP_INV_V: begin ms_a = gv_q;             ms_b = inv_q;        end
      default:  begin ms_a = acc_q;            ms_b = inv_q;        end
    endcase

    ms_full = {prod, 32'd0} + {32'd0, ms_lo_q};
    ms_res  = (|ms_full[95:64+FRAC_BITS]) ? '1 : ms_full[63+FRAC_BITS:FRAC_BITS];

    acc_sum = {1'b0, acc_q} + {1'b0, ms_res};
    acc_nxt = acc_sum[64] ? '1 : acc_sum[63:0];

    // Multiplier operand select
    unique case (state_q)
      S_MU:    mul_op = '{a: mu_q, b: mu_q};
      S_MV:    mul_op = '{a: mv_q, b: mv_q};
      S_DS:    mul_op = '{a: {1'b0, thr_q}, b: {1'b0, thr_q}};
      S_LIN1:  mul_op = '{a: {1'b0, thr_q}, b: mag_q};
      S_MS0:   mul_op = '{a: ms_a[31:0], b: ms_b};
      S_MS1:   mul_op = '{a: ms_a[63:32], b: ms_b};
      default: mul_op = '{a: 32'd0, b: 32'd0};
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign done_fire   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      thr_q       <= 31'(64'd1 << FRAC_BITS);
      inv_q       <= 32'(64'd1 << FRAC_BITS);
      usew_q      <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      mu_q <= '0; mv_q <= '0; w_q <= '0; mag_q <= '0;
      neg_u_q <= 1'b0; neg_v_q <= 1'b0; last_q <= 1'b0;
      rsq_q <= '0; dsq_q <= '0; rho_q <= '0; sq_res_q <= '0; sq_bit_q <= '0;
      ms_lo_q <= '0; gu_q <= '0; gv_q <= '0; total_q <= '0;
      div_q <= '0; rem_q <= '0; cnt_q <= '0; op_q <= OP_TERM;
    end else begin
      // Register writes
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_THRESHOLD: thr_q  <= cfg_data_i[30:0];
          CFG_INV_NORM:  inv_q  <= cfg_data_i;
          CFG_USE_WGT:   usew_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      // Load a new result, or drop the held one once taken
      if (done_fire) out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            neg_u_q <= in_data_i.res_u[31];
            neg_v_q <= in_data_i.res_v[31];
            mu_q    <= in_data_i.res_u[31] ? 32'(-in_data_i.res_u) : in_data_i.res_u;
            mv_q    <= in_data_i.res_v[31] ? 32'(-in_data_i.res_v) : in_data_i.res_v;
            w_q     <= usew_q ? in_data_i.weight : 32'(64'd1 << FRAC_BITS);
            last_q  <= in_data_i.last;
            state_q <= S_MU;
          end
        end
        S_MU: state_q <= S_MV;
        S_MV: begin
          rsq_q   <= prod;
          state_q <= S_DS;
        end
        S_DS: begin
          rsq_q   <= rsq_q + prod;
          state_q <= S_CMP;
        end
        // Pick quadratic or linear zone
        S_CMP: begin
          dsq_q <= prod;
          if (rsq_q <= prod) begin
            rho_q   <= {1'b0, rsq_q[63:1]};
            div_q   <= DIV_W'(64'd1 << FRAC_BITS);
            op_q    <= OP_TERM;
            state_q <= S_MS0;
          end else begin
            sq_res_q <= '0;
            sq_bit_q <= 64'd1 << 62;
            cnt_q    <= CNT_W'(SQRT_ITER - 1);
            state_q  <= S_SQRT;
          end
        end
        // One square-root digit per cycle
        S_SQRT: begin
          if (sq_ge) rsq_q <= rsq_q - sq_rb;
          sq_res_q <= sq_res_nxt;
          sq_bit_q <= sq_bit_q >> 2;
          cnt_q    <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            mag_q   <= sq_res_nxt[31:0];
            state_q <= S_LIN1;
          end
        end
        S_LIN1: state_q <= S_LIN2;
        S_LIN2: begin
          rho_q   <= prod - {1'b0, dsq_q[63:1]};
          div_q   <= {thr_q, FRAC_BITS'(0)};
          rem_q   <= '0;
          cnt_q   <= CNT_W'(DIV_W - 1);
          state_q <= S_DIV;
        end
        // One quotient bit per cycle
        S_DIV: begin
          rem_q <= div_ge ? (div_sh - {1'b0, mag_q}) : div_sh;
          div_q <= {div_q[DIV_W-2:0], div_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            op_q    <= OP_TERM;
            state_q <= S_MS0;
          end
        end
        S_MS0: state_q <= S_MS1;
        S_MS1: begin
          ms_lo_q <= prod;
          state_q <= S_MS2;
        end
        // Combine partial products and retire the operation
        S_MS2: begin
          unique case (op_q)
            OP_TERM:                    acc_q   <= acc_nxt;
            OP_FAC_U, OP_WGT_U, OP_INV_U: gu_q  <= ms_res;
            OP_FAC_V, OP_WGT_V, OP_INV_V: gv_q  <= ms_res;
            default:                    total_q <= ms_res;
          endcase
          if (op_q == OP_TOTAL || (op_q == OP_INV_V && !last_q)) begin
            state_q <= S_DONE;
          end else begin
            op_q    <= op_q + 3'd1;
            state_q <= S_MS0;
          end
        end
        // Hand the result to the output register
        S_DONE: begin
          if (done_fire) begin
            out_q.grad_u       <= sat32(gu_q, neg_u_q);
            out_q.grad_v       <= sat32(gv_q, neg_v_q);
            out_q.sum_valid    <= last_q;
            out_q.misfit_total <= !last_q ? 63'd0 :
                                  (total_q[63] ? '1 : total_q[62:0]);
            if (last_q) acc_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "huber_vector_misfit_gradient_assert.svh"

  `HVMG_ASSERT_NXT(a_accept_starts, in_valid_i && in_ready_o, state_q == S_MU)
  `HVMG_ASSERT_NOW(a_sqrt_bit_onehot, state_q == S_SQRT, $onehot(sq_bit_q))
  `HVMG_ASSERT_NOW(a_div_rem_bound, state_q == S_DIV, rem_q < {1'b0, mag_q})
  `HVMG_ASSERT_NOW(a_total_only_last, out_valid_q && !out_q.sum_valid,
                   out_q.misfit_total == 63'd0)

endmodule

`default_nettype wire
